FILE: rtl/multi_button_debouncer_macros.svh
// ----------------------------------------------------------------------------
// multi_button_debouncer_macros
// assertion macros used by the debouncer checker
// ----------------------------------------------------------------------------
`ifndef MULTI_BUTTON_DEBOUNCER_MACROS_SVH
`define MULTI_BUTTON_DEBOUNCER_MACROS_SVH

// implication checked outside reset
`define MBD_ASSERT_IMPLY(label, ante, conseq, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (conseq)) \
      else $error(msg);

// next-cycle implication checked outside reset
`define MBD_ASSERT_NEXT(label, ante, conseq, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (conseq)) \
      else $error(msg);

// next-cycle implication checked at every edge, reset included
`define MBD_ASSERT_NEXT_ALWAYS(label, ante, conseq, msg) \
   label: assert property (@(posedge clock) (ante) |=> (conseq)) \
      else $error(msg);

`endif

FILE: rtl/mbd_pkg.sv
// ----------------------------------------------------------------------------
// mbd_pkg
// types and constants of the multi-button debouncer
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mbd_pkg;

   localparam int NUM_BUTTONS         = 5;
   localparam int COUNT_WIDTH_DEFAULT = 8;
   localparam int THRESH_WIDTH        = 8;
   localparam int IDX_WIDTH           = 3;
   localparam int EVENT_WIDTH         = 2;
   localparam int CSR_INDEX_WIDTH     = 2;
   localparam int CSR_DATA_WIDTH      = 8;

   typedef logic [NUM_BUTTONS-1:0]     levels_type;
   typedef logic [THRESH_WIDTH-1:0]    thresh_type;
   typedef logic [IDX_WIDTH-1:0]       idx_type;
   typedef logic [EVENT_WIDTH-1:0]     event_type;
   typedef logic [CSR_INDEX_WIDTH-1:0] csr_index_type;
   typedef logic [CSR_DATA_WIDTH-1:0]  csr_data_type;

   localparam logic OP_POLL  = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   localparam event_type EV_NONE     = 2'd0;
   localparam event_type EV_PUSHED   = 2'd1;
   localparam event_type EV_RELEASED = 2'd2;

   localparam csr_index_type CSR_RISE_THRESHOLD = 2'd0;
   localparam csr_index_type CSR_FALL_THRESHOLD = 2'd1;
   localparam csr_index_type CSR_NORMAL_LEVELS  = 2'd2;

   localparam thresh_type RISE_THRESHOLD_RESET = 8'd3;
   localparam thresh_type FALL_THRESHOLD_RESET = 8'd3;
   localparam levels_type NORMAL_LEVELS_RESET  = 5'd0;

   typedef struct packed {
      logic       opcode;
      levels_type pin_levels;
      idx_type    button_index;
   } req_type;

   typedef struct packed {
      event_type  change_event;
      levels_type debounced_levels;
   } rsp_type;

   typedef struct packed {
      thresh_type rise_threshold;
      thresh_type fall_threshold;
      levels_type normal_levels;
   } cfg_type;

   typedef struct packed {
      logic poll_step;
      logic query_step;
      logic raw;
   } cell_ctrl_type;

endpackage

FILE: rtl/mbd_csr.sv
// ----------------------------------------------------------------------------
// mbd_csr
// configuration registers: thresholds and normal levels
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mbd_csr (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  mbd_pkg::csr_index_type csr_index,
   input  mbd_pkg::csr_data_type  csr_wdata,
   output mbd_pkg::cfg_type       cfg
);

   mbd_pkg::cfg_type cfg_ff;
   mbd_pkg::cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            mbd_pkg::CSR_RISE_THRESHOLD: begin
               cfg_in.rise_threshold = mbd_pkg::THRESH_WIDTH'(csr_wdata);
            end
            mbd_pkg::CSR_FALL_THRESHOLD: begin
               cfg_in.fall_threshold = mbd_pkg::THRESH_WIDTH'(csr_wdata);
            end
            mbd_pkg::CSR_NORMAL_LEVELS: begin
               cfg_in.normal_levels = mbd_pkg::NUM_BUTTONS'(csr_wdata);
            end
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.rise_threshold <= mbd_pkg::RISE_THRESHOLD_RESET;
         cfg_ff.fall_threshold <= mbd_pkg::FALL_THRESHOLD_RESET;
         cfg_ff.normal_levels  <= mbd_pkg::NORMAL_LEVELS_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

FILE: rtl/mbd_cell.sv
// ----------------------------------------------------------------------------
// mbd_cell
// one button: settled level, saturating mismatch counter, sticky change flag
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mbd_cell #(
   parameter int COUNT_WIDTH = mbd_pkg::COUNT_WIDTH_DEFAULT,
   parameter bit LEVEL_RESET = 1'b0
) (
   input  logic                  clock,
   input  logic                  reset,
   input  mbd_pkg::cell_ctrl_type ctrl,
   input  mbd_pkg::thresh_type   rise_threshold,
   input  mbd_pkg::thresh_type   fall_threshold,
   input  logic                  normal_level,
   output logic                  level_next,
   output mbd_pkg::event_type    change_event
);

   localparam int CmpWidth =
      (COUNT_WIDTH > mbd_pkg::THRESH_WIDTH) ? COUNT_WIDTH : mbd_pkg::THRESH_WIDTH;
   localparam logic [COUNT_WIDTH-1:0] CountMax = '1;

   logic                   level_ff;
   logic                   level_in;
   logic                   flag_ff;
   logic                   flag_in;
   logic [COUNT_WIDTH-1:0] count_ff;
   logic [COUNT_WIDTH-1:0] count_in;
   logic [COUNT_WIDTH-1:0] count_inc;
   mbd_pkg::thresh_type    need;
   logic                   adopt;

   assign count_inc = (count_ff == CountMax) ? count_ff : count_ff + 1'b1;
   assign need      = ctrl.raw ? rise_threshold : fall_threshold;
   assign adopt     = CmpWidth'(count_inc) >= CmpWidth'(need);

   always_comb begin
      level_in = level_ff;
      flag_in  = flag_ff;
      count_in = count_ff;
      if (ctrl.poll_step) begin
         if (ctrl.raw != level_ff) begin
            if (adopt) begin
               level_in = ctrl.raw;
               flag_in  = 1'b1;
               count_in = '0;
            end else begin
               count_in = count_inc;
            end
         end else begin
            count_in = '0;
         end
      end else if (ctrl.query_step) begin
         flag_in = 1'b0;
      end
   end

   always_comb begin
      change_event = mbd_pkg::EV_NONE;
      if (ctrl.query_step && flag_ff) begin
         change_event = (level_ff == normal_level) ? mbd_pkg::EV_RELEASED
                                                   : mbd_pkg::EV_PUSHED;
      end
   end

   assign level_next = level_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff <= LEVEL_RESET;
         flag_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         level_ff <= level_in;
         flag_ff  <= flag_in;
         count_ff <= count_in;
      end
   end

endmodule

FILE: rtl/multi_button_debouncer.sv
// ----------------------------------------------------------------------------
// multi_button_debouncer
// counter debouncer for five buttons with sticky change flags
// ----------------------------------------------------------------------------
// usage
//   req channel: a poll (opcode 0) carries raw pin levels, a query (opcode 1)
//   names a button and reads and clears its change flag
//   rsp channel: one transfer per request, with the query answer (none,
//   pushed, released) and the debounced levels after the request
//   csr channel: thresholds and normal levels, always ready, write when idle
// timing
//   a request lands in an input register, then, once the output is free, the
//   button cells update and the result register loads; one request per cycle
//   is sustained while responses are taken
//   the button state is per-button flip-flops, all updated on the same edge
// reset
//   clears both pipeline valid bits, counters and flags, and sets levels and
//   registers to their reset values; req_ready is high after reset
// stall
//   while rsp is held, the response stays put and one more request waits in
//   the input register; req_ready then drops until the response moves
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module multi_button_debouncer #(
   parameter int COUNT_WIDTH = mbd_pkg::COUNT_WIDTH_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  mbd_pkg::req_type       req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output mbd_pkg::rsp_type       rsp_data,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  mbd_pkg::csr_index_type csr_index,
   input  mbd_pkg::csr_data_type  csr_wdata
);

   mbd_pkg::cfg_type    cfg;
   logic                s1_valid_ff;
   logic                s1_valid_in;
   mbd_pkg::req_type    s1_data_ff;
   logic                rsp_valid_ff;
   logic                rsp_valid_in;
   mbd_pkg::rsp_type    rsp_data_ff;
   mbd_pkg::rsp_type    rsp_data_in;
   logic                out_free;
   logic                advance;
   mbd_pkg::levels_type level_next;
   mbd_pkg::event_type  lane_event [mbd_pkg::NUM_BUTTONS];

   mbd_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign advance   = s1_valid_ff && out_free;
   assign req_ready = !s1_valid_ff || out_free;

   for (genvar i = 0; i < mbd_pkg::NUM_BUTTONS; i++) begin : g_cell
      mbd_pkg::cell_ctrl_type ctrl;

      assign ctrl.poll_step  = advance && (s1_data_ff.opcode == mbd_pkg::OP_POLL);
      assign ctrl.query_step = advance && (s1_data_ff.opcode == mbd_pkg::OP_QUERY)
                               && (s1_data_ff.button_index == mbd_pkg::idx_type'(i));
      assign ctrl.raw        = s1_data_ff.pin_levels[i];

      mbd_cell #(
         .COUNT_WIDTH (COUNT_WIDTH),
         .LEVEL_RESET (mbd_pkg::NORMAL_LEVELS_RESET[i])
      ) u_cell (
         .clock          (clock),
         .reset          (reset),
         .ctrl           (ctrl),
         .rise_threshold (cfg.rise_threshold),
         .fall_threshold (cfg.fall_threshold),
         .normal_level   (cfg.normal_levels[i]),
         .level_next     (level_next[i]),
         .change_event   (lane_event[i])
      );
   end

   always_comb begin
      rsp_data_in.change_event     = mbd_pkg::EV_NONE;
      rsp_data_in.debounced_levels = level_next;
      for (int i = 0; i < mbd_pkg::NUM_BUTTONS; i++) begin
         rsp_data_in.change_event = rsp_data_in.change_event | lane_event[i];
      end
   end

   assign s1_valid_in  = req_ready ? req_valid : s1_valid_ff;
   assign rsp_valid_in = out_free ? s1_valid_ff : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         s1_data_ff <= req_data;
      end
      if (advance) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

FILE: rtl/mbd_checker.sv
// ----------------------------------------------------------------------------
// mbd_checker
// port-level checks of the debouncer handshakes and latency
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "multi_button_debouncer_macros.svh"

module mbd_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input mbd_pkg::rsp_type rsp_data
);

   logic req_fire;
   logic out_free;
   logic rsp_stall;

   assign req_fire  = req_valid && req_ready;
   assign out_free  = !rsp_valid || rsp_ready;
   assign rsp_stall = rsp_valid && !rsp_ready;

   // stalled response holds
   `MBD_ASSERT_NEXT(a_rsp_hold, rsp_stall, rsp_valid && $stable(rsp_data), "rsp not held")

   // an accepted request reaches the output once the output is free
   `MBD_ASSERT_NEXT(a_req_to_rsp, req_fire ##1 out_free, rsp_valid, "request lost")

   // back pressure only from a stalled response
   `MBD_ASSERT_IMPLY(a_ready_low, !req_ready, rsp_stall, "req_ready low without rsp stall")

   // empty and ready right after reset
   `MBD_ASSERT_NEXT_ALWAYS(a_reset_empty, reset, !rsp_valid && req_ready, "busy after reset")

endmodule

bind multi_button_debouncer mbd_checker u_mbd_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

FILE: tb/tb_multi_button_debouncer.sv
// ----------------------------------------------------------------------------
// tb_multi_button_debouncer
// self-checking bench for the five-button counter debouncer
// ----------------------------------------------------------------------------
// polls and queries go in on the req channel with random gaps. A scoreboard
// keeps its own copy of the levels, counters, change flags and registers,
// works out the response of every accepted request, and compares each
// response transfer field by field. Register settings change between phases,
// once all responses are back: reset values, zero and one thresholds, full
// scale thresholds with long steady holds, and random small ones. One phase
// runs without gaps while the response side holds off for a long stretch.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

typedef logic [mbd_pkg::COUNT_WIDTH_DEFAULT-1:0] count_type;

class debounce_scoreboard;
   localparam int COUNT_MAX = (1 << mbd_pkg::COUNT_WIDTH_DEFAULT) - 1;

   mbd_pkg::thresh_type rise_threshold;
   mbd_pkg::thresh_type fall_threshold;
   mbd_pkg::levels_type normal_levels;
   mbd_pkg::levels_type settled;
   mbd_pkg::levels_type changed;
   count_type           mismatches [mbd_pkg::NUM_BUTTONS];
   mbd_pkg::rsp_type    expected_q [$];
   int                  errors;

   function void restart();
      rise_threshold = mbd_pkg::RISE_THRESHOLD_RESET;
      fall_threshold = mbd_pkg::FALL_THRESHOLD_RESET;
      normal_levels  = mbd_pkg::NORMAL_LEVELS_RESET;
      settled        = mbd_pkg::NORMAL_LEVELS_RESET;
      changed        = '0;
      foreach (mismatches[i]) mismatches[i] = '0;
      expected_q.delete();
      errors = 0;
   endfunction

   function void note_write(mbd_pkg::csr_index_type idx, mbd_pkg::csr_data_type data);
      case (idx)
         mbd_pkg::CSR_RISE_THRESHOLD: rise_threshold = data;
         mbd_pkg::CSR_FALL_THRESHOLD: fall_threshold = data;
         mbd_pkg::CSR_NORMAL_LEVELS:  normal_levels  = data[mbd_pkg::NUM_BUTTONS-1:0];
         default: ;
      endcase
   endfunction

   function void note_request(mbd_pkg::req_type r);
      mbd_pkg::rsp_type    outcome;
      mbd_pkg::thresh_type need;
      outcome.change_event = mbd_pkg::EV_NONE;
      if (r.opcode == mbd_pkg::OP_POLL) begin
         for (int i = 0; i < mbd_pkg::NUM_BUTTONS; i++) begin
            if (r.pin_levels[i] != settled[i]) begin
               need = r.pin_levels[i] ? rise_threshold : fall_threshold;
               if (mismatches[i] != COUNT_MAX) mismatches[i]++;
               if (mismatches[i] >= need) begin
                  settled[i]    = r.pin_levels[i];
                  changed[i]    = 1'b1;
                  mismatches[i] = '0;
               end
            end else begin
               mismatches[i] = '0;
            end
         end
      end else if (r.button_index < mbd_pkg::NUM_BUTTONS && changed[r.button_index]) begin
         changed[r.button_index] = 1'b0;
         outcome.change_event = (settled[r.button_index] == normal_levels[r.button_index]) ?
                                mbd_pkg::EV_RELEASED : mbd_pkg::EV_PUSHED;
      end
      outcome.debounced_levels = settled;
      expected_q.push_back(outcome);
   endfunction

   task report(string what);
      errors++;
      if (errors <= 50) $display("mismatch: %s", what);
   endtask

   task check_response(mbd_pkg::rsp_type got);
      mbd_pkg::rsp_type want;
      if (expected_q.size() == 0) begin
         report($sformatf("response 0x%0h with nothing expected", got));
         return;
      end
      want = expected_q.pop_front();
      if (got.change_event != want.change_event)
         report($sformatf("change_event %0d, expected %0d", got.change_event,
                          want.change_event));
      if (got.debounced_levels != want.debounced_levels)
         report($sformatf("debounced_levels 0x%0h, expected 0x%0h",
                          got.debounced_levels, want.debounced_levels));
   endtask
endclass

module tb_multi_button_debouncer;

   localparam int                     CYCLE_LIMIT     = 200000;
   localparam int                     HOLD_CYCLES     = 64;
   localparam int                     IDLE_PCT        = 29;
   localparam mbd_pkg::csr_index_type CSR_SPARE_INDEX = 2'd3;

   logic                   clock;
   logic                   reset     = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   mbd_pkg::req_type       req_data  = '0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   mbd_pkg::rsp_type       rsp_data;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   mbd_pkg::csr_index_type csr_index = '0;
   mbd_pkg::csr_data_type  csr_wdata = '0;

   bit calm        = 1'b0;
   int holds_asked = 0;
   int cycle_count = 0;

   debounce_scoreboard sb = new();

   multi_button_debouncer dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("CHECK FAILED");
      $finish;
   end

   // response side: random stalls, plus long hold-offs on request
   initial begin
      int hold_left;
      int holds_served;
      hold_left    = 0;
      holds_served = 0;
      forever begin
         @(posedge clock);
         if (rsp_valid && rsp_ready) sb.check_response(rsp_data);
         if (holds_served < holds_asked) begin
            holds_served++;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
         end
      end
   end

   function automatic mbd_pkg::req_type poll_item(mbd_pkg::levels_type pins);
      mbd_pkg::req_type r;
      r.opcode       = mbd_pkg::OP_POLL;
      r.pin_levels   = pins;
      r.button_index = mbd_pkg::idx_type'($urandom_range(0, 7));
      return r;
   endfunction

   function automatic mbd_pkg::req_type query_item(mbd_pkg::idx_type idx);
      mbd_pkg::req_type r;
      r.opcode       = mbd_pkg::OP_QUERY;
      r.pin_levels   = mbd_pkg::levels_type'($urandom_range(0, 31));
      r.button_index = idx;
      return r;
   endfunction

   task automatic send_request(input mbd_pkg::req_type r);
      if (!calm) begin
         while ($urandom_range(0, 99) < IDLE_PCT) begin
            req_valid <= 1'b0;
            @(posedge clock);
         end
      end
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (!req_ready);
      sb.note_request(r);
   endtask

   task automatic write_register(input mbd_pkg::csr_index_type idx,
                                 input mbd_pkg::csr_data_type data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      sb.note_write(idx, data);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (sb.expected_q.size() != 0) @(posedge clock);
   endtask

   task automatic run_phase(input mbd_pkg::thresh_type rise, input mbd_pkg::thresh_type fall,
                            input mbd_pkg::csr_data_type normal, input int n_items,
                            input int query_pct, input int noise_pct,
                            input int run_min, input int run_max, input bit steady);
      mbd_pkg::levels_type target;
      mbd_pkg::levels_type pins;
      int                  run_left;
      wait_drained();
      write_register(mbd_pkg::CSR_RISE_THRESHOLD, rise);
      write_register(mbd_pkg::CSR_FALL_THRESHOLD, fall);
      write_register(mbd_pkg::CSR_NORMAL_LEVELS, normal);
      csr_valid <= 1'b0;
      calm = steady;
      if (steady) holds_asked++;
      target   = sb.settled;
      run_left = 0;
      repeat (n_items) begin
         if ($urandom_range(0, 99) < query_pct) begin
            if ($urandom_range(0, 99) < 85)
               send_request(query_item(
                  mbd_pkg::idx_type'($urandom_range(0, mbd_pkg::NUM_BUTTONS - 1))));
            else
               send_request(query_item(
                  mbd_pkg::idx_type'($urandom_range(mbd_pkg::NUM_BUTTONS, 7))));
         end else begin
            if (run_left == 0) begin
               target  ^= mbd_pkg::levels_type'($urandom_range(1, 31));
               run_left = $urandom_range(run_min, run_max);
            end
            run_left--;
            pins = target;
            if ($urandom_range(0, 99) < noise_pct)
               pins ^= mbd_pkg::levels_type'(1) << $urandom_range(0, mbd_pkg::NUM_BUTTONS - 1);
            send_request(poll_item(pins));
         end
      end
      calm = 1'b0;
   endtask

   initial begin
      sb.restart();
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // reset settings: no flag yet, all pushed, bounce then release
      send_request(query_item(mbd_pkg::idx_type'(0)));
      repeat (4) send_request(poll_item(5'b11111));
      for (int b = 0; b < 8; b++) send_request(query_item(mbd_pkg::idx_type'(b)));
      repeat (2) send_request(poll_item(5'b00000));
      send_request(poll_item(5'b11111));
      repeat (3) send_request(poll_item(5'b00000));
      send_request(query_item(mbd_pkg::idx_type'(0)));
      send_request(poll_item(5'b10101));
      send_request(poll_item(5'b01010));

      // unmapped register index
      wait_drained();
      write_register(CSR_SPARE_INDEX, 8'hff);

      run_phase(8'd1, 8'd1, 8'hff, 90, 25, 5, 1, 4, 1'b0);
      run_phase(8'd0, 8'd0, mbd_pkg::csr_data_type'($urandom_range(0, 255)), 90, 25, 10, 1, 3,
                1'b0);
      run_phase(8'd255, 8'd255, 8'h15, 330, 8, 0, 256, 300, 1'b0);
      run_phase(8'd2, 8'd7, mbd_pkg::csr_data_type'($urandom_range(0, 255)), 130, 25, 10, 1, 10,
                1'b1);
      repeat (3) begin
         run_phase(mbd_pkg::thresh_type'($urandom_range(1, 12)),
                   mbd_pkg::thresh_type'($urandom_range(1, 12)),
                   mbd_pkg::csr_data_type'($urandom_range(0, 255)), 100, 30, 10, 1, 16, 1'b0);
      end

      wait_drained();
      repeat (10) @(posedge clock);
      if (sb.errors == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

FILE: filelist.f
+incdir+rtl
rtl/mbd_pkg.sv
rtl/mbd_csr.sv
rtl/mbd_cell.sv
rtl/multi_button_debouncer.sv
rtl/mbd_checker.sv
tb/tb_multi_button_debouncer.sv
